FILE: sv/vfjb_pkg.sv
// Package for the voice frame jitter buffer: ring geometry, silence and sync
// constants, pointer arithmetic helpers and the types shared by the modules.
// No dependencies.
package vfjb_pkg;

   localparam int RING_SLOTS  = 63;
   localparam int SYNC_PERIOD = 21;
   localparam int PTR_W       = $clog2(RING_SLOTS);
   localparam int NUM_W       = 8;
   localparam int OUT_W       = 6;
   localparam int WORD_W      = 32;
   localparam int GAP_LIMIT   = RING_SLOTS / 3;

   localparam logic [WORD_W-1:0] SIL_W0     = 32'h8e4fb8b0;
   localparam logic [WORD_W-1:0] SIL_W1     = 32'hd55f2ba0;
   localparam logic [WORD_W-1:0] SIL_W2     = 32'he81629f5;
   localparam logic [23:0]       SYNC_BYTES = 24'h552D16;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef enum logic [1:0] {
      OP_RESTART  = 2'd0,
      OP_WRITE    = 2'd1,
      OP_SEND     = 2'd2,
      OP_SET_STOP = 2'd3
   } op_type;

   typedef struct packed {
      logic [WORD_W-1:0] word0;
      logic [WORD_W-1:0] word1;
      logic [WORD_W-1:0] word2;
   } frame_type;

   // Commands from the sequencer to the slot store.
   typedef struct packed {
      logic      wr_en;
      ptr_type   wr_idx;
      frame_type wr_data;
      logic      rd_en;
      ptr_type   rd_idx;
      logic      clr_en;
      ptr_type   clr_idx;
      logic      clr_all;
   } store_cmd_type;

   typedef struct packed {
      frame_type        frame;
      logic             last_frame;
      logic             buffer_empty;
      logic             write_accepted;
      logic [OUT_W-1:0] unsent_count;
      logic [OUT_W-1:0] read_position;
   } result_type;

   localparam ptr_type          LAST_SLOT = PTR_W'(RING_SLOTS - 1);
   localparam logic [PTR_W:0]   RING_EXT  = (PTR_W + 1)'(RING_SLOTS);
   localparam logic [NUM_W-1:0] RING_NUM  = NUM_W'(RING_SLOTS);

   function automatic logic [RING_SLOTS-1:0] sync_mask_f();
      logic [RING_SLOTS-1:0] m;
      m = '0;
      for (int i = 0; i < RING_SLOTS; i++) begin
         m[i] = ((i % SYNC_PERIOD) == 0);
      end
      return m;
   endfunction

   localparam logic [RING_SLOTS-1:0] SYNC_MASK = sync_mask_f();

   function automatic ptr_type ptr_inc(input ptr_type p);
      return (p == LAST_SLOT) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      return (p == '0) ? LAST_SLOT : ptr_type'(p - 1'b1);
   endfunction

   // (a - b) modulo the ring size, both operands already inside the ring.
   function automatic ptr_type ring_diff(input ptr_type a, input ptr_type b);
      if (a >= b) begin
         return ptr_type'(a - b);
      end
      return PTR_W'({1'b0, a} + RING_EXT - {1'b0, b});
   endfunction

   function automatic frame_type silence_f(input ptr_type idx);
      frame_type f;
      f.word0 = SIL_W0;
      f.word1 = SIL_W1;
      f.word2 = SYNC_MASK[idx] ? {SIL_W2[31:24], SYNC_BYTES} : SIL_W2;
      return f;
   endfunction

endpackage

FILE: sv/vfjb_if.sv
// Channel interfaces of the voice frame jitter buffer: the request channel
// and the response channel, each with valid/ready handshake. Uses vfjb_pkg.
interface vfjb_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  operation;
   logic [vfjb_pkg::NUM_W-1:0]  slot_number;
   logic [vfjb_pkg::WORD_W-1:0] frame_word0;
   logic [vfjb_pkg::WORD_W-1:0] frame_word1;
   logic [vfjb_pkg::WORD_W-1:0] frame_word2;

   modport source (output valid, operation, slot_number, frame_word0, frame_word1,
                   frame_word2, input ready);
   modport sink (input valid, operation, slot_number, frame_word0, frame_word1,
                 frame_word2, output ready);
endinterface

interface vfjb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vfjb_pkg::WORD_W-1:0] sent_word0;
   logic [vfjb_pkg::WORD_W-1:0] sent_word1;
   logic [vfjb_pkg::WORD_W-1:0] sent_word2;
   logic                        last_frame;
   logic                        buffer_empty;
   logic                        write_accepted;
   logic [vfjb_pkg::OUT_W-1:0]  unsent_count;
   logic [vfjb_pkg::OUT_W-1:0]  read_position;

   modport source (output valid, sent_word0, sent_word1, sent_word2, last_frame,
                   buffer_empty, write_accepted, unsent_count, read_position,
                   input ready);
   modport sink (input valid, sent_word0, sent_word1, sent_word2, last_frame,
                 buffer_empty, write_accepted, unsent_count, read_position,
                 output ready);
endinterface

FILE: sv/vfjb_slot_store.sv
// Slot store of the voice frame jitter buffer: frame memory with one write
// port and one registered read port, plus per-slot valid bits. Uses vfjb_pkg.
module vfjb_slot_store (
   input  logic                    clock,
   input  logic                    reset,
   input  vfjb_pkg::store_cmd_type cmd,
   output vfjb_pkg::frame_type     rd_frame
);
   import vfjb_pkg::*;

   frame_type             ring_mem [RING_SLOTS];
   logic [RING_SLOTS-1:0] valid_ff, valid_in;
   frame_type             rd_data_ff;
   ptr_type               rd_idx_ff;
   logic                  rd_hit_ff;

   // A slot without its valid bit reads as silence, so restart and the
   // restore behind a send only touch the valid bits.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clr_all) begin
         valid_in = '0;
      end else begin
         if (cmd.clr_en) begin
            valid_in[cmd.clr_idx] = 1'b0;
         end
         if (cmd.wr_en) begin
            valid_in[cmd.wr_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ring_mem[cmd.wr_idx] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[cmd.rd_idx];
         rd_idx_ff  <= cmd.rd_idx;
         rd_hit_ff  <= valid_ff[cmd.rd_idx];
      end
   end

   assign rd_frame = rd_hit_ff ? rd_data_ff : silence_f(rd_idx_ff);

endmodule

FILE: sv/voice_frame_jitter_buffer.sv
// Voice frame jitter buffer top level. The result is registered in res_ff and
// moves to the response register once the response channel is free; a send
// first passes the read state, which waits on the slot memory's registered read.
// A request is taken only in the idle state; a new request is taken while a
// response still waits. Synchronous reset clears the positions and all valid bits.
module voice_frame_jitter_buffer (
   input logic        clock,
   input logic        reset,
   vfjb_req_if.sink   req_chan,
   vfjb_rsp_if.source rsp_chan
);
   import vfjb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   ptr_type       rd_ptr_ff, rd_ptr_in;
   ptr_type       wr_ptr_ff, wr_ptr_in;
   ptr_type       stop_ptr_ff, stop_ptr_in;
   logic          empty_ff, empty_in;
   result_type    res_ff, res_in;
   result_type    rsp_ff;
   logic          rsp_valid_ff;
   store_cmd_type cmd;
   frame_type     rd_frame;
   logic          req_take;
   logic          rsp_free;
   logic          num_ok;
   ptr_type       num_p;
   ptr_type       rd_next;

   vfjb_slot_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_frame (rd_frame)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign num_ok         = (req_chan.slot_number < RING_NUM);
   assign num_p          = PTR_W'(req_chan.slot_number);
   assign rd_next        = ptr_inc(rd_ptr_ff);

   always_comb begin
      state_in    = state_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      stop_ptr_in = stop_ptr_ff;
      empty_in    = empty_ff;
      res_in      = res_ff;
      cmd         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_in = '0;
               case (op_type'(req_chan.operation))
                  OP_RESTART: begin
                     cmd.clr_all = 1'b1;
                     rd_ptr_in   = '0;
                     wr_ptr_in   = '0;
                     stop_ptr_in = '0;
                     empty_in    = 1'b0;
                  end
                  OP_WRITE: begin
                     stop_ptr_in = rd_ptr_ff;
                     // Out-of-range numbers and the slot just sent are dropped.
                     if (num_ok && (num_p != ptr_dec(rd_ptr_ff))) begin
                        cmd.wr_en         = 1'b1;
                        cmd.wr_idx        = num_p;
                        cmd.wr_data.word0 = req_chan.frame_word0;
                        cmd.wr_data.word1 = req_chan.frame_word1;
                        cmd.wr_data.word2 = req_chan.frame_word2;
                        if (num_p == wr_ptr_ff) begin
                           wr_ptr_in = ptr_inc(wr_ptr_ff);
                        end else if (ring_diff(num_p, wr_ptr_ff) < PTR_W'(GAP_LIMIT)) begin
                           wr_ptr_in = ptr_inc(num_p);
                        end
                        empty_in              = 1'b0;
                        res_in.write_accepted = 1'b1;
                     end
                  end
                  OP_SEND: begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_idx  = rd_ptr_ff;
                     cmd.clr_en  = 1'b1;
                     cmd.clr_idx = ptr_dec(rd_ptr_ff);
                     wr_ptr_in   = wr_ptr_ff;
                     // An empty ring sends silence and drags the write side along.
                     if (rd_ptr_ff == wr_ptr_ff) begin
                        empty_in  = 1'b1;
                        wr_ptr_in = ptr_inc(wr_ptr_ff);
                     end
                     rd_ptr_in = rd_next;
                     if (rd_next == stop_ptr_ff) begin
                        res_in.last_frame = 1'b1;
                        wr_ptr_in         = rd_next;
                     end else if (rd_next == wr_ptr_in) begin
                        empty_in = 1'b1;
                     end
                  end
                  OP_SET_STOP: begin
                     if (empty_ff) begin
                        stop_ptr_in = rd_next;
                     end else if (num_ok) begin
                        stop_ptr_in = num_p;
                     end else begin
                        stop_ptr_in = wr_ptr_ff;
                     end
                  end
                  default: begin
                     stop_ptr_in = stop_ptr_ff;
                  end
               endcase
               res_in.buffer_empty  = empty_in;
               res_in.unsent_count  = OUT_W'(ring_diff(wr_ptr_in, rd_ptr_in));
               res_in.read_position = OUT_W'(rd_ptr_in);
               state_in = (op_type'(req_chan.operation) == OP_SEND) ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            res_in.frame = rd_frame;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         stop_ptr_ff  <= '0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         stop_ptr_ff <= stop_ptr_in;
         empty_ff    <= empty_in;
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.sent_word0     = rsp_ff.frame.word0;
   assign rsp_chan.sent_word1     = rsp_ff.frame.word1;
   assign rsp_chan.sent_word2     = rsp_ff.frame.word2;
   assign rsp_chan.last_frame     = rsp_ff.last_frame;
   assign rsp_chan.buffer_empty   = rsp_ff.buffer_empty;
   assign rsp_chan.write_accepted = rsp_ff.write_accepted;
   assign rsp_chan.unsent_count   = rsp_ff.unsent_count;
   assign rsp_chan.read_position  = rsp_ff.read_position;

endmodule

FILE: sv/vfjb_checker.sv
// Port-level checker for the voice frame jitter buffer and the bind that
// attaches it to the top level. Uses vfjb_pkg.
module vfjb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [vfjb_pkg::WORD_W-1:0] rsp_word0,
   input logic [vfjb_pkg::WORD_W-1:0] rsp_word1,
   input logic [vfjb_pkg::WORD_W-1:0] rsp_word2,
   input logic                        rsp_last,
   input logic                        rsp_empty,
   input logic                        rsp_accepted,
   input logic [vfjb_pkg::OUT_W-1:0]  rsp_unsent,
   input logic [vfjb_pkg::OUT_W-1:0]  rsp_rdpos
);
   import vfjb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // One transaction at a time: no request is taken in the cycle after one.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(req_valid && req_ready))
      else $error("request taken in back-to-back cycles");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unsent < RING_SLOTS) && (rsp_rdpos < RING_SLOTS))
      else $error("position outside the ring");

   // Reaching the stop position pulls the write side onto the read side.
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_unsent == '0) && !rsp_accepted)
      else $error("last frame with unsent frames left");

   a_write_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_empty && (rsp_word0 == '0) &&
                                     (rsp_word1 == '0) && (rsp_word2 == '0))
      else $error("stored write reports empty or a sent frame");

endmodule

bind voice_frame_jitter_buffer vfjb_checker u_vfjb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_word0    (rsp_chan.sent_word0),
   .rsp_word1    (rsp_chan.sent_word1),
   .rsp_word2    (rsp_chan.sent_word2),
   .rsp_last     (rsp_chan.last_frame),
   .rsp_empty    (rsp_chan.buffer_empty),
   .rsp_accepted (rsp_chan.write_accepted),
   .rsp_unsent   (rsp_chan.unsent_count),
   .rsp_rdpos    (rsp_chan.read_position)
);
